FILE: rtl/wsr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the work size regulator.
// Used by the core, the trim engine and the port checker; no dependencies.
package wsr_pkg;

   localparam int unsigned TARGET_RESET = 1000000;
   localparam int unsigned WORK_RESET   = 10000;

   localparam logic [2:0] KIND_HOLD    = 3'd0;
   localparam logic [2:0] KIND_QUAD    = 3'd1;
   localparam logic [2:0] KIND_DOUBLE  = 3'd2;
   localparam logic [2:0] KIND_QUARTER = 3'd3;
   localparam logic [2:0] KIND_HALF    = 3'd4;
   localparam logic [2:0] KIND_TRIM    = 3'd5;

   localparam int QUO_WIDTH  = 34;
   localparam int RES_WIDTH  = 35;
   localparam int ROOT_WIDTH = 17;
   localparam int FRAC_BITS  = 16;
   localparam int BIT_START  = 32;
   localparam int CNT_WIDTH  = 6;
   localparam int DIV_STEPS  = 34;
   localparam int ROOT_STEPS = 17;
   localparam int MUL_STEPS  = 17;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_TRIM,
      S_WRITE
   } core_state_type;

   typedef enum logic [2:0] {
      T_IDLE,
      T_DIV,
      T_SQRT,
      T_MUL,
      T_DONE
   } trim_state_type;

   typedef struct packed {
      logic done;
      logic saturated;
   } trim_stat_type;

endpackage

FILE: rtl/wsr_trim.sv
`timescale 1ns / 1ps
// Square-root trim engine: quotient, root and product on one shared adder.
// Depends on wsr_pkg.
module wsr_trim #(
   parameter int WORK_WIDTH = 48,
   parameter int TIME_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [TIME_WIDTH-2:0]     target,
   input  logic [TIME_WIDTH-2:0]     meas,
   input  logic [WORK_WIDTH-1:0]     work,
   output logic [WORK_WIDTH-1:0]     trim_work,
   output wsr_pkg::trim_stat_type    stat
);
   import wsr_pkg::*;

   localparam int MW  = WORK_WIDTH + ROOT_WIDTH;
   localparam int UW0 = (MW > RES_WIDTH) ? MW : RES_WIDTH;
   localparam int UW  = (UW0 > TIME_WIDTH) ? UW0 : TIME_WIDTH;

   trim_state_type         state_ff, state_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [TIME_WIDTH-1:0]  rem_ff, rem_in;
   logic [TIME_WIDTH-2:0]  den_ff, den_in;
   logic [QUO_WIDTH-1:0]   quo_ff, quo_in;
   logic [RES_WIDTH-1:0]   res_ff, res_in;
   logic [QUO_WIDTH-1:0]   bit_ff, bit_in;
   logic [MW-1:0]          acc_ff, acc_in;

   logic [UW-1:0]          alu_a, alu_b;
   logic                   alu_sub;
   logic [UW:0]            alu_sum;
   logic                   alu_carry;

   assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b ^ {UW{alu_sub}}} + (UW+1)'(alu_sub);
   assign alu_carry = alu_sum[UW];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (start) state_in = T_DIV;
         end
         T_DIV: begin
            if (cnt_ff == '0) state_in = T_SQRT;
         end
         T_SQRT: begin
            if (cnt_ff == '0) state_in = T_MUL;
         end
         T_MUL: begin
            if (cnt_ff == '0) state_in = T_DONE;
         end
         T_DONE: begin
            state_in = T_IDLE;
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      cnt_in  = cnt_ff - CNT_WIDTH'(1);
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      acc_in  = acc_ff;
      unique case (state_ff)
         T_IDLE: begin
            cnt_in = CNT_WIDTH'(DIV_STEPS - 1);
            if (start) begin
               rem_in = TIME_WIDTH'(target >> 2);
               quo_in = {target[1:0], 32'd0};
               den_in = meas;
               res_in = '0;
               bit_in = QUO_WIDTH'(1) << BIT_START;
               acc_in = '0;
            end
         end
         T_DIV: begin
            alu_a   = UW'({rem_ff[TIME_WIDTH-2:0], quo_ff[QUO_WIDTH-1]});
            alu_b   = UW'(den_ff);
            alu_sub = 1'b1;
            rem_in  = alu_carry ? alu_sum[TIME_WIDTH-1:0] : alu_a[TIME_WIDTH-1:0];
            quo_in  = {quo_ff[QUO_WIDTH-2:0], alu_carry};
            if (cnt_ff == '0) cnt_in = CNT_WIDTH'(ROOT_STEPS - 1);
         end
         T_SQRT: begin
            alu_a   = UW'(quo_ff);
            alu_b   = UW'(res_ff | RES_WIDTH'(bit_ff));
            alu_sub = 1'b1;
            if (alu_carry) begin
               quo_in = alu_sum[QUO_WIDTH-1:0];
               res_in = (res_ff >> 1) | RES_WIDTH'(bit_ff);
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (cnt_ff == '0) cnt_in = CNT_WIDTH'(MUL_STEPS - 1);
         end
         T_MUL: begin
            alu_a  = UW'({acc_ff[MW-2:0], 1'b0});
            alu_b  = res_ff[ROOT_WIDTH-1] ? UW'(work) : '0;
            acc_in = alu_sum[MW-1:0];
            res_in = res_ff << 1;
         end
         T_DONE: begin
            cnt_in = cnt_ff;
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      acc_ff <= acc_in;
   end

   assign stat.done      = (state_ff == T_DONE);
   assign stat.saturated = acc_ff[MW-1];
   assign trim_work      = acc_ff[MW-1] ? '1 : acc_ff[WORK_WIDTH+FRAC_BITS-1:FRAC_BITS];

endmodule

FILE: rtl/work_size_time_regulator_core.sv
`timescale 1ns / 1ps
// Work size regulator top level: channels, work register and band select.
// Depends on wsr_pkg and wsr_trim.
//
// Usage:
//   req_ channel carries one measured busy time (signed ns) per beat.
//   rsp_ channel returns one beat per request: new work amount, adjust
//   kind and a saturation flag. csr_write_en writes csr_target_time.
//   req_ready is high only while no request is in work; one request is
//   handled at a time.
//   The hold, times four, double, quarter and half bands go from the
//   evaluate state straight to the write state; the square-root trim band
//   waits on the trim engine's shared adder, which produces one quotient
//   bit per cycle, then one root bit per cycle, then one multiplier bit
//   per cycle.
//   The response sits in an output register; a new request is accepted
//   while it waits, and a finished result waits until that register frees.
//   Reset sets the work amount to 10000, the target to 1000000 ns and
//   empties both channels.
module work_size_time_regulator_core #(
   parameter int WORK_WIDTH = 48,
   parameter int TIME_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [TIME_WIDTH-1:0] req_measured_time,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [WORK_WIDTH-1:0]        rsp_work_amount,
   output logic [2:0]                   rsp_adjust_kind,
   output logic                         rsp_saturated,
   input  logic                         csr_write_en,
   input  logic [TIME_WIDTH-2:0]        csr_target_time
);
   import wsr_pkg::*;

   localparam int CW = TIME_WIDTH + 2;

   core_state_type         state_ff, state_in;
   logic [TIME_WIDTH-2:0]  target_ff, target_in;
   logic [TIME_WIDTH-1:0]  meas_ff, meas_in;
   logic [WORK_WIDTH-1:0]  work_ff, work_in;
   logic [2:0]             kind_ff, kind_in;
   logic                   sat_ff, sat_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WORK_WIDTH-1:0]  rsp_work_ff;
   logic [2:0]             rsp_kind_ff;
   logic                   rsp_sat_ff;

   logic [TIME_WIDTH-2:0]  meas_mag;
   logic [TIME_WIDTH-2:0]  target_eff;
   logic [CW-1:0]          a1, a2, a4, t1, t2, t4;
   logic                   is_neg, is_quad, is_double, is_quarter, is_half;
   logic                   accept, trim_start, rsp_load;
   logic [WORK_WIDTH-1:0]  trim_work;
   trim_stat_type          trim_stat;

   assign accept     = req_valid && req_ready;
   assign meas_mag   = meas_ff[TIME_WIDTH-2:0];
   assign target_eff = (target_ff == '0) ? (TIME_WIDTH-1)'(1) : target_ff;
   assign is_neg     = meas_ff[TIME_WIDTH-1];
   assign a1         = CW'(meas_mag);
   assign a2         = CW'({meas_mag, 1'b0});
   assign a4         = CW'({meas_mag, 2'b00});
   assign t1         = CW'(target_eff);
   assign t2         = CW'({target_eff, 1'b0});
   assign t4         = CW'({target_eff, 2'b00});
   assign is_quad    = a4 < t1;
   assign is_double  = a2 < t1;
   assign is_quarter = a1 > t4;
   assign is_half    = a1 > t2;

   wsr_trim #(
      .WORK_WIDTH(WORK_WIDTH),
      .TIME_WIDTH(TIME_WIDTH)
   ) u_trim (
      .clock     (clock),
      .reset     (reset),
      .start     (trim_start),
      .target    (target_eff),
      .meas      (meas_mag),
      .work      (work_ff),
      .trim_work (trim_work),
      .stat      (trim_stat)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EVAL;
         end
         S_EVAL: begin
            if (!is_neg && !is_quad && !is_double && !is_quarter && !is_half) begin
               state_in = S_TRIM;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_TRIM: begin
            if (trim_stat.done) state_in = S_WRITE;
         end
         S_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      trim_start = 1'b0;
      rsp_load   = 1'b0;
      work_in    = work_ff;
      kind_in    = kind_ff;
      sat_in     = sat_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_EVAL: begin
            sat_in = 1'b0;
            if (is_neg) begin
               kind_in = KIND_HOLD;
            end else if (is_quad) begin
               kind_in = KIND_QUAD;
               if (work_ff[WORK_WIDTH-1:WORK_WIDTH-2] != 2'b00) begin
                  work_in = '1;
                  sat_in  = 1'b1;
               end else begin
                  work_in = work_ff << 2;
               end
            end else if (is_double) begin
               kind_in = KIND_DOUBLE;
               if (work_ff[WORK_WIDTH-1]) begin
                  work_in = '1;
                  sat_in  = 1'b1;
               end else begin
                  work_in = work_ff << 1;
               end
            end else if (is_quarter) begin
               kind_in = KIND_QUARTER;
               work_in = work_ff >> 2;
            end else if (is_half) begin
               kind_in = KIND_HALF;
               work_in = work_ff >> 1;
            end else begin
               kind_in    = KIND_TRIM;
               trim_start = 1'b1;
            end
         end
         S_TRIM: begin
            if (trim_stat.done) begin
               work_in = trim_work;
               sat_in  = trim_stat.saturated;
            end
         end
         S_WRITE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: req_ready = 1'b0;
      endcase
   end

   assign target_in    = csr_write_en ? csr_target_time : target_ff;
   assign meas_in      = accept ? req_measured_time : meas_ff;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         target_ff    <= (TIME_WIDTH-1)'(TARGET_RESET);
         work_ff      <= WORK_WIDTH'(WORK_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         work_ff      <= work_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff <= meas_in;
      kind_ff <= kind_in;
      sat_ff  <= sat_in;
      if (rsp_load) begin
         rsp_work_ff <= work_ff;
         rsp_kind_ff <= kind_ff;
         rsp_sat_ff  <= sat_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_work_amount = rsp_work_ff;
   assign rsp_adjust_kind = rsp_kind_ff;
   assign rsp_saturated   = rsp_sat_ff;

endmodule

FILE: rtl/wsr_core_chk.sv
`timescale 1ns / 1ps
// Port checker for the work size regulator core, bound to the top level.
// Depends on wsr_pkg and work_size_time_regulator_core.
module wsr_core_chk #(
   parameter int WORK_WIDTH = 48
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [WORK_WIDTH-1:0]        rsp_work_amount,
   input logic [2:0]                   rsp_adjust_kind,
   input logic                         rsp_saturated
);
   import wsr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_work_amount)
         && $stable(rsp_adjust_kind) && $stable(rsp_saturated))
      else $error("response beat changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in work");

   a_sat_is_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> (rsp_work_amount == {WORK_WIDTH{1'b1}}))
      else $error("saturated beat without maximum work");

   a_no_sat_on_shrink: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_adjust_kind == KIND_HOLD || rsp_adjust_kind == KIND_QUARTER
         || rsp_adjust_kind == KIND_HALF) |-> !rsp_saturated)
      else $error("saturation flagged on a non-growing adjust");

endmodule

bind work_size_time_regulator_core wsr_core_chk #(
   .WORK_WIDTH(WORK_WIDTH)
) u_wsr_core_chk (.*);

FILE: verif/work_size_time_regulator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of work_size_time_regulator_core: directed and random
// measurements checked against a work-amount predictor, with stalls on both channels.
// Depends on wsr_pkg and the regulator RTL.
module work_size_time_regulator_core_tb;
   import wsr_pkg::*;

   localparam int WORK_W = 48;
   localparam int TIME_W = 32;
   localparam longint unsigned WORK_MAX = (64'd1 << WORK_W) - 64'd1;
   localparam longint unsigned TIME_POS_MAX = (64'd1 << (TIME_W - 1)) - 64'd1;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 100;
   localparam int PHASES = 16;
   localparam int PHASE_BEATS = 100;
   localparam int HOLD_OFF_CYCLES = 500;

   typedef struct packed {
      logic [WORK_W-1:0] work_amount;
      logic [2:0]        adjust_kind;
      logic              saturated;
   } work_result_type;

   class work_ledger;
      logic [TIME_W-2:0] target;
      logic [WORK_W-1:0] work;
      work_result_type   expected_q[$];
      int unsigned       errors;

      function new();
         target = (TIME_W-1)'(TARGET_RESET);
         work   = WORK_W'(WORK_RESET);
         errors = 0;
      endfunction

      function void set_target(logic [TIME_W-2:0] value);
         target = value;
      endfunction

      function longint unsigned floor_root(longint unsigned x);
         longint unsigned root;
         longint unsigned one;
         root = 0;
         one  = 64'd1 << 62;
         while (one > x)
            one = one >> 2;
         while (one != 0) begin
            if (x >= root + one) begin
               x    = x - (root + one);
               root = (root >> 1) + one;
            end else begin
               root = root >> 1;
            end
            one = one >> 2;
         end
         return root;
      endfunction

      function work_result_type next_work(logic signed [TIME_W-1:0] measured);
         longint unsigned t, a, w, f, prod;
         work_result_type r;
         t = (target == 0) ? 64'd1 : 64'(target);
         w = 64'(work);
         r.adjust_kind = KIND_HOLD;
         r.saturated   = 1'b0;
         if (!measured[TIME_W-1]) begin
            a = 64'(measured);
            if (4 * a < t) begin
               r.adjust_kind = KIND_QUAD;
               if (w > (WORK_MAX >> 2)) begin
                  w = WORK_MAX;
                  r.saturated = 1'b1;
               end else begin
                  w = w << 2;
               end
            end else if (2 * a < t) begin
               r.adjust_kind = KIND_DOUBLE;
               if (w > (WORK_MAX >> 1)) begin
                  w = WORK_MAX;
                  r.saturated = 1'b1;
               end else begin
                  w = w << 1;
               end
            end else if (a > 4 * t) begin
               r.adjust_kind = KIND_QUARTER;
               w = w >> 2;
            end else if (a > 2 * t) begin
               r.adjust_kind = KIND_HALF;
               w = w >> 1;
            end else begin
               r.adjust_kind = KIND_TRIM;
               f = floor_root((t << 32) / a);
               prod = (w >> 16) * f + (((w & 64'hFFFF) * f) >> 16);
               if (prod > WORK_MAX) begin
                  prod = WORK_MAX;
                  r.saturated = 1'b1;
               end
               w = prod;
            end
            work = w[WORK_W-1:0];
         end
         r.work_amount = work;
         return r;
      endfunction

      function void note_measurement(logic signed [TIME_W-1:0] measured);
         expected_q.push_back(next_work(measured));
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 50)
            $display("mismatch at %0d ns: %s", $time, msg);
      endtask

      task check_result(logic [WORK_W-1:0] work_amount, logic [2:0] adjust_kind,
                        logic saturated);
         work_result_type due;
         if (expected_q.size() == 0) begin
            report($sformatf("beat with no request outstanding, work_amount %0d", work_amount));
            return;
         end
         due = expected_q.pop_front();
         if (work_amount !== due.work_amount)
            report($sformatf("work_amount %0d, expected %0d", work_amount, due.work_amount));
         if (adjust_kind !== due.adjust_kind)
            report($sformatf("adjust_kind %0d, expected %0d", adjust_kind, due.adjust_kind));
         if (saturated !== due.saturated)
            report($sformatf("saturated %0b, expected %0b", saturated, due.saturated));
      endtask
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic signed [TIME_W-1:0] req_measured_time;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [WORK_W-1:0]        rsp_work_amount;
   logic [2:0]               rsp_adjust_kind;
   logic                     rsp_saturated;
   logic                     csr_write_en;
   logic [TIME_W-2:0]        csr_target_time;

   work_ledger ledger;
   int         quiet_cycles = 0;

   logic signed [TIME_W-1:0] directed_beats [14] = '{
      32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1,
      TARGET_RESET / 4 - 1, TARGET_RESET / 4, TARGET_RESET / 2 - 1, TARGET_RESET / 2,
      TARGET_RESET, 2 * TARGET_RESET, 2 * TARGET_RESET + 1, 4 * TARGET_RESET,
      4 * TARGET_RESET + 1, 32'sh7FFF_FFFF
   };

   work_size_time_regulator_core #(
      .WORK_WIDTH (WORK_W),
      .TIME_WIDTH (TIME_W)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_measured_time (req_measured_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_work_amount   (rsp_work_amount),
      .rsp_adjust_kind   (rsp_adjust_kind),
      .rsp_saturated     (rsp_saturated),
      .csr_write_en      (csr_write_en),
      .csr_target_time   (csr_target_time)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, 3);
      if (r < 96)
         return $urandom_range(4, 20);
      return $urandom_range(30, 150);
   endfunction

   function automatic logic [2:0] pick_band(bit rising);
      int r;
      r = $urandom_range(0, 99);
      if (rising) begin
         if (r < 35) return KIND_QUAD;
         if (r < 65) return KIND_DOUBLE;
         if (r < 85) return KIND_TRIM;
         if (r < 93) return KIND_HALF;
         return KIND_QUARTER;
      end
      if (r < 8) return KIND_QUAD;
      if (r < 15) return KIND_DOUBLE;
      if (r < 40) return KIND_TRIM;
      if (r < 70) return KIND_HALF;
      return KIND_QUARTER;
   endfunction

   function automatic logic signed [TIME_W-1:0] band_measure(longint unsigned te,
                                                              logic [2:0] band);
      longint unsigned lo, hi;
      int              r;
      lo = 1;
      hi = 0;
      while (lo > hi) begin
         case (band)
            KIND_QUAD: begin
               lo = 0;
               hi = (te - 1) / 4;
            end
            KIND_DOUBLE: begin
               lo = (te + 3) / 4;
               hi = (te - 1) / 2;
               if (lo > hi) band = KIND_QUAD;
            end
            KIND_TRIM: begin
               lo = (te + 1) / 2;
               hi = (2 * te < TIME_POS_MAX) ? 2 * te : TIME_POS_MAX;
            end
            KIND_HALF: begin
               lo = 2 * te + 1;
               hi = (4 * te < TIME_POS_MAX) ? 4 * te : TIME_POS_MAX;
               if (lo > hi) band = KIND_TRIM;
            end
            default: begin
               lo = 4 * te + 1;
               hi = TIME_POS_MAX;
               if (lo > hi) band = KIND_HALF;
            end
         endcase
      end
      r = $urandom_range(0, 9);
      if (r < 2)
         return lo[TIME_W-1:0];
      if (r < 4)
         return hi[TIME_W-1:0];
      return $urandom_range(32'(hi), 32'(lo));
   endfunction

   // Steer toward growth while the work is small so it does not collapse to zero.
   function automatic logic signed [TIME_W-1:0] next_measure(bit rising, bit steer);
      longint unsigned te;
      int              r;
      te = (ledger.target == 0) ? 64'd1 : 64'(ledger.target);
      r  = $urandom_range(0, 99);
      if (steer && ledger.work < 64)
         return band_measure(te, KIND_QUAD);
      if (r < 10)
         return $urandom;
      if (r < 16)
         return $urandom | 32'h8000_0000;
      return band_measure(te, pick_band(rising));
   endfunction

   function automatic logic [TIME_W-2:0] pick_target(int phase);
      if (phase == 1) return '0;
      if (phase == 2) return '1;
      if (phase == 3) return (TIME_W-1)'(1);
      case (phase % 6)
         0: return (TIME_W-1)'($urandom_range(1, 1000));
         1: return {(TIME_W-1){1'b1}} - (TIME_W-1)'($urandom_range(1, 3));
         2: return (TIME_W-1)'($urandom);
         3: return (TIME_W-1)'($urandom_range(2, 3));
         4: return (TIME_W-1)'(TARGET_RESET - 1000 + $urandom_range(0, 2000));
         default: return (TIME_W-1)'($urandom_range(1, 1 << 20));
      endcase
   endfunction

   task automatic offer(logic signed [TIME_W-1:0] measured, int idle_pct);
      int gap;
      req_valid         <= 1'b1;
      req_measured_time <= measured;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      ledger.note_measurement(measured);
      gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic await_idle();
      req_valid <= 1'b0;
      while (ledger.expected_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_target(logic [TIME_W-2:0] value);
      await_idle();
      csr_target_time <= value;
      csr_write_en    <= 1'b1;
      @(posedge clock);
      csr_write_en    <= 1'b0;
      ledger.set_target(value);
   endtask

   initial begin
      int idle_pct;
      bit rising;
      ledger = new();
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_measured_time <= '0;
      csr_write_en      <= 1'b0;
      csr_target_time   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_beats[i])
         offer(directed_beats[i], 0);
      rising = 1'b1;
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0)
            write_target(pick_target(phase));
         else
            await_idle();
         idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (n % 25 == 0)
               rising = 1'($urandom_range(0, 1));
            offer(next_measure(rising, phase != PHASES - 1), idle_pct);
         end
      end
      await_idle();
      if (ledger.errors == 0 && ledger.expected_q.size() == 0)
         $display("work_size_time_regulator_core_tb: PASS");
      else
         $display("work_size_time_regulator_core_tb: FAIL");
      $finish;
   end

   // Result side: random stalls, quiet windows, and one long hold-off to back up the block.
   initial begin
      int stall_left;
      int stall_pct;
      int window;
      int beats;
      bit held;
      stall_left = 0;
      stall_pct  = 0;
      window     = 0;
      beats      = 0;
      held       = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            beats++;
         if (window == 0) begin
            window    = 200;
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
         end
         window--;
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!held && beats >= 300) begin
            held       = 1'b1;
            stall_left = HOLD_OFF_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = pick_gap() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_result(rsp_work_amount, rsp_adjust_kind, rsp_saturated);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles < QUIET_LIMIT) begin
         quiet_cycles++;
      end else begin
         $display("work_size_time_regulator_core_tb: FAIL");
         $finish;
      end
   end

endmodule

FILE: filelist.f
rtl/wsr_pkg.sv
rtl/wsr_trim.sv
rtl/work_size_time_regulator_core.sv
rtl/wsr_core_chk.sv
verif/work_size_time_regulator_core_tb.sv
